// ----- hdl/bf3h_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3h_pkg
// shared constants, types and hash step functions of the three-hash filter
// ----------------------------------------------------------------------------
package bf3h_pkg;

  localparam int MAX_FILTER_BITS = 65536;
  localparam int HASH_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int SIZE_W          = 17;                       // register and count width
  localparam int POS_W           = $clog2(MAX_FILTER_BITS);  // bit position width
  localparam int DIV_W           = POS_W + 1;                // effective size width
  localparam int WORD_W          = 32;                       // bits per store row
  localparam int ROWS            = MAX_FILTER_BITS / WORD_W;
  localparam int ROW_W           = $clog2(ROWS);
  localparam int BIT_W           = $clog2(WORD_W);
  localparam int STEP_W          = $clog2(HASH_W);
  localparam int NUM_HASH        = 3;
  localparam int IDX_W           = $clog2(NUM_HASH);

  localparam logic [HASH_W-1:0] SEED_FNV       = 32'd2166136261;
  localparam logic [HASH_W-1:0] PRIME_FNV      = 32'd16777619;
  localparam logic [HASH_W-1:0] SEED_SHIFT_XOR = 32'h5bd1e995;
  localparam logic [HASH_W-1:0] SEED_TIMES31   = 32'h811c9dc5;

  localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(MAX_FILTER_BITS);
  localparam logic [IDX_W-1:0]  LAST_IDX       = IDX_W'(NUM_HASH - 1);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  // status from the remainder unit
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_result_t;

  function automatic logic [HASH_W-1:0] sext_byte(input logic [BYTE_W-1:0] b);
    return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return t * PRIME_FNV;
  endfunction

  function automatic logic [HASH_W-1:0] shift_xor_step(input logic [HASH_W-1:0] h,
                                                       input logic [BYTE_W-1:0] b);
    return ((h << 5) + h) ^ sext_byte(b);
  endfunction

  function automatic logic [HASH_W-1:0] times31_step(input logic [HASH_W-1:0] h,
                                                     input logic [BYTE_W-1:0] b);
    return (h << 5) - h + sext_byte(b);
  endfunction

  // zero and oversize both mean the full store
  function automatic logic [DIV_W-1:0] eff_size(input logic [SIZE_W-1:0] cfg);
    if (cfg == '0 || 32'(cfg) > 32'(MAX_FILTER_BITS)) begin
      return DIV_W'(MAX_FILTER_BITS);
    end
    return DIV_W'(cfg);
  endfunction

endpackage

// ----- hdl/bf3h_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3h_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bf3h_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/bf3h_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3h_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bf3h_mod
  import bf3h_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output mod_result_t       result
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [HASH_W-1:0] dvd;
  logic [DIV_W-1:0]  dsr;
  logic [POS_W-1:0]  rem;
  logic [DIV_W-1:0]  trial;

  // shift in the next dividend bit
  assign trial = {rem, dvd[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= dsr) begin
        rem <= POS_W'(trial - dsr);
      end else begin
        rem <= POS_W'(trial);
      end
    end
  end

  assign result.done = done;
  assign result.rem  = rem;

endmodule

// ----- hdl/bloom_filter_three_hash_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_three_hash_top
// three-hash bloom filter over byte-stream keys with add and query
// ----------------------------------------------------------------------------
//
// channel  | dir | tdata                         | tuser                 | tlast
// ---------+-----+-------------------------------+-----------------------+----------
// s_axis   | in  | key_byte                      | operation, byte_valid | last_byte
// m_axis   | out | maybe_present, count, refill  | -                     | -
// cfg      | in  | filter_size write (cfg_we)    | -                     | -
//
// key bytes that are not last are taken one per cycle and hashed at once
// the last item of a key holds the block for three passes of the shared
// bit-serial remainder unit plus a read and a read-modify-write of the 32-bit
// store row per position, then the result is loaded into the output register
// after reset a clearing pass zeroes all 2048 store rows; no item is taken
// a waiting result sits in the output register; bytes of the next key are
// still taken, and a finished key waits for the register to drain
//
module bloom_filter_three_hash_top
  import bf3h_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,     // filter_size
  // input items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] key_byte
  input  logic [1:0]        s_axis_tuser,  // [0] operation, [1] byte_valid
  input  logic              s_axis_tlast,  // last_byte
  // result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata   // [0] maybe_present, [17:1] set_bit_count,
                                           // [18] refill_advised, [23:19] zero
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  clr_row;
  logic [SIZE_W-1:0] filter_size;
  logic [DIV_W-1:0]  size_eff;

  // running hashes and the snapshot taken on the last item
  logic [HASH_W-1:0] hash_fnv;
  logic [HASH_W-1:0] hash_shift_xor;
  logic [HASH_W-1:0] hash_times31;
  logic [HASH_W-1:0] fnv_cur;
  logic [HASH_W-1:0] sx_cur;
  logic [HASH_W-1:0] t31_cur;
  logic [HASH_W-1:0] hold [NUM_HASH];

  logic              op;
  logic              present;
  logic [IDX_W-1:0]  pos_idx;
  logic [POS_W-1:0]  pos;
  logic [SIZE_W-1:0] set_count;

  logic              in_accept;
  logic              key_end;
  logic              bit_hit;
  logic              do_set;
  logic              out_load;

  // remainder unit hookup
  logic              mod_start;
  logic [HASH_W-1:0] mod_dividend;
  mod_result_t       mod_res;

  // store ram
  logic              ram_we;
  logic [ROW_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // output register
  logic              out_valid;
  logic              out_present;
  logic [SIZE_W-1:0] out_count;
  logic              out_refill;

  assign size_eff      = eff_size(filter_size);
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign key_end       = in_accept && s_axis_tlast;

  // hash step for this item, or hold the value for an empty slot
  always_comb begin
    if (s_axis_tuser[1]) begin
      fnv_cur = fnv_step(hash_fnv, s_axis_tdata);
      sx_cur  = shift_xor_step(hash_shift_xor, s_axis_tdata);
      t31_cur = times31_step(hash_times31, s_axis_tdata);
    end else begin
      fnv_cur = hash_fnv;
      sx_cur  = hash_shift_xor;
      t31_cur = hash_times31;
    end
  end

  // first pass starts on the last item, later passes after each row update
  assign mod_start    = key_end || (state == S_CHECK && pos_idx != LAST_IDX);
  assign mod_dividend = key_end ? fnv_cur : hold[IDX_W'(pos_idx + 1'b1)];

  bf3h_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (size_eff),
    .result   (mod_res)
  );

  // row read-modify-write
  assign bit_hit = ram_rdata[pos[BIT_W-1:0]];
  assign do_set  = (state == S_CHECK) && (op == OP_ADD) && !bit_hit;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pos[POS_W-1:BIT_W];
    ram_wdata = ram_rdata | (WORD_W'(1) << pos[BIT_W-1:0]);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_row;
        ram_wdata = '0;
      end
      S_CHECK: begin
        ram_we = do_set;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bf3h_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_load = (state == S_DONE) && (!out_valid || m_axis_tready);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_row        <= '0;
      filter_size    <= SIZE_RESET;
      hash_fnv       <= SEED_FNV;
      hash_shift_xor <= SEED_SHIFT_XOR;
      hash_times31   <= SEED_TIMES31;
      set_count      <= '0;
      pos_idx        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_size <= cfg_wdata;
      end

      if (in_accept) begin
        if (s_axis_tlast) begin
          hash_fnv       <= SEED_FNV;
          hash_shift_xor <= SEED_SHIFT_XOR;
          hash_times31   <= SEED_TIMES31;
        end else begin
          hash_fnv       <= fnv_cur;
          hash_shift_xor <= sx_cur;
          hash_times31   <= t31_cur;
        end
      end

      if (do_set) begin
        set_count <= set_count + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (key_end) begin
            pos_idx <= '0;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_res.done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (pos_idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            pos_idx <= pos_idx + 1'b1;
            state   <= S_MOD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (key_end) begin
      hold[0] <= fnv_cur;
      hold[1] <= sx_cur;
      hold[2] <= t31_cur;
      op      <= s_axis_tuser[0];
      present <= 1'b1;
    end else if (state == S_CHECK && op == OP_QUERY && !bit_hit) begin
      present <= 1'b0;
    end
    if (state == S_MOD && mod_res.done) begin
      pos <= mod_res.rem;
    end
    if (out_load) begin
      out_present <= present;
      out_count   <= set_count;
      out_refill  <= ((32'(set_count) << 1) >= 32'(size_eff)) &&
                     (32'(size_eff) < 32'(MAX_FILTER_BITS));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_refill, out_count, out_present};

endmodule

// ----- hdl/bf3h_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3h_checker
// port-level checks on the three-hash filter, bound to the top level
// ----------------------------------------------------------------------------
module bf3h_checker (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [23:0]       m_axis_tdata
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result item present after reset");

  // clearing pass follows reset, no item taken
  a_rst_clear: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("item taken during clearing pass");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  // key bytes stream at one per cycle
  a_byte_rate: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("not ready after a key byte");

  // end of key starts the position sequence
  a_key_end: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready straight after end of key");

endmodule

bind bloom_filter_three_hash_top bf3h_checker u_checker (.*);
